// ----- rtl/chessboard_distance_transform_unit_defines.svh -----
// ----------------------------------------------------------------------------
// chessboard distance transform - assertion macros
// shared helpers for the concurrent checks in the rtl modules
// ----------------------------------------------------------------------------
`ifndef CHESSBOARD_DISTANCE_TRANSFORM_UNIT_DEFINES_SVH
`define CHESSBOARD_DISTANCE_TRANSFORM_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cdt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_pkg
// types, codes and neighbour table of the chessboard distance transform
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int DEF_MAX_WIDTH     = 128;
    localparam int DEF_MAX_HEIGHT    = 128;
    localparam int DEF_DISTANCE_BITS = 16;

    localparam int CFG_BITS  = 8;
    localparam int DIM_RESET = 128;

    // command codes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // configuration register index
    typedef enum logic [0:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  cell_x;
        logic [6:0]  cell_y;
        logic [15:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic        out_of_range;
    } out_item_t;

    // sweep engine status toward the command side
    typedef struct packed {
        logic busy;
        logic done;
    } sweep_stat_t;

    typedef enum logic [1:0] {
        SW_IDLE,
        SW_FWD,
        SW_BWD
    } sweep_state_t;

    // per-cell step of the sweep engine
    localparam logic [2:0] PHASE_CENTER   = 3'd0;
    localparam logic [2:0] PHASE_NB_FIRST = 3'd1;
    localparam logic [2:0] PHASE_NB_LAST  = 3'd4;
    localparam logic [2:0] PHASE_WRITE    = 3'd5;

    // neighbour move, north is +y
    typedef struct packed {
        logic x_dec;
        logic x_inc;
        logic y_dec;
        logic y_inc;
    } nb_step_t;

    // directions 0..7: E, SE, S, SW, W, NW, N, NE
    function automatic nb_step_t nb_step(input logic [2:0] dir);
        nb_step_t s;
        s = '0;
        case (dir)
            3'd0: s.x_inc = 1'b1;
            3'd1: begin s.x_inc = 1'b1; s.y_dec = 1'b1; end
            3'd2: s.y_dec = 1'b1;
            3'd3: begin s.x_dec = 1'b1; s.y_dec = 1'b1; end
            3'd4: s.x_dec = 1'b1;
            3'd5: begin s.x_dec = 1'b1; s.y_inc = 1'b1; end
            3'd6: s.y_inc = 1'b1;
            3'd7: begin s.x_inc = 1'b1; s.y_inc = 1'b1; end
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/chessboard_distance_transform_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chessboard_distance_transform_unit
// stored grid of distances with write, read and two-pass chessboard transform
// ----------------------------------------------------------------------------
// write and read: one item accepted per cycle while not busy; result strobe from the
//   pending stage through the result register. run: busy while the sweep works, each
//   cell and pass taking the single memory port for center read, four neighbour reads,
//   write back; run result strobe registered from the last write back
// rst_n clears control state and restores 128 by 128; the grid memory is not cleared
// results cannot be held off; exactly one result per accepted item
`include "chessboard_distance_transform_unit_defines.svh"

module chessboard_distance_transform_unit #(
    parameter int MAX_WIDTH     = cdt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = cdt_pkg::DEF_MAX_HEIGHT,
    parameter int DISTANCE_BITS = cdt_pkg::DEF_DISTANCE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  cdt_pkg::in_item_t             cmd,
    // result channel
    output logic                          done,
    output cdt_pkg::out_item_t            result,
    // configuration write port
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [cdt_pkg::CFG_BITS-1:0]  cfg_data
);

    import cdt_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int DWW   = $clog2(MAX_WIDTH + 1);
    localparam int DWH   = $clog2(MAX_HEIGHT + 1);
    localparam int GW_RST = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
    localparam int GH_RST = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

    // grid size registers, clamped on write
    logic [DWW-1:0] gw_reg, gw_next;
    logic [DWH-1:0] gh_reg, gh_next;

    // result pipeline: stage one waits for memory read data
    logic pend_valid_reg, pend_valid_next;
    logic pend_read_reg, pend_read_next;
    logic pend_oor_reg, pend_oor_next;
    logic done_reg, done_next;
    out_item_t result_reg, result_next;

    logic                     accept, oor;
    logic                     cmd_en, cmd_we;
    logic [AW-1:0]            cmd_addr;
    logic                     sw_run, sw_en, sw_we;
    logic [AW-1:0]            sw_addr;
    logic [DISTANCE_BITS-1:0] sw_wdata;
    sweep_stat_t              sw_stat;

    logic                     mem_en, mem_we;
    logic [AW-1:0]            mem_addr;
    logic [DISTANCE_BITS-1:0] mem_wdata, mem_rdata;

    // an item goes in whenever no run is in progress
    assign busy   = sw_stat.busy;
    assign accept = start && !busy;
    assign oor    = (32'(cmd.cell_x) >= 32'(gw_reg)) || (32'(cmd.cell_y) >= 32'(gh_reg));
    assign cmd_addr = AW'(AW'(cmd.cell_y) * AW'(MAX_WIDTH) + AW'(cmd.cell_x));

    always_comb
    begin
        cmd_en = 1'b0;
        cmd_we = 1'b0;
        sw_run = 1'b0;
        pend_valid_next = 1'b0;
        pend_read_next  = 1'b0;
        pend_oor_next   = 1'b0;
        if (accept)
        begin
            case (op_t'(cmd.operation))
                OP_WRITE:
                begin
                    // out-of-range writes are dropped
                    cmd_en          = !oor;
                    cmd_we          = !oor;
                    pend_valid_next = 1'b1;
                    pend_oor_next   = oor;
                end
                OP_READ:
                begin
                    cmd_en          = !oor;
                    pend_valid_next = 1'b1;
                    pend_read_next  = !oor;
                    pend_oor_next   = oor;
                end
                OP_RUN:
                begin
                    // result comes from the sweep when it finishes
                    sw_run = 1'b1;
                end
                default:
                begin
                    // unused code: empty result
                    pend_valid_next = 1'b1;
                end
            endcase
        end
    end

    // memory port belongs to the sweep while it runs
    always_comb
    begin
        if (sw_stat.busy)
        begin
            mem_en    = sw_en;
            mem_we    = sw_we;
            mem_addr  = sw_addr;
            mem_wdata = sw_wdata;
        end
        else
        begin
            mem_en    = cmd_en;
            mem_we    = cmd_we;
            mem_addr  = cmd_addr;
            mem_wdata = DISTANCE_BITS'(cmd.write_value);
        end
    end

    // result register, fed by the pending stage or the sweep end
    always_comb
    begin
        done_next   = pend_valid_reg || sw_stat.done;
        result_next = '0;
        if (pend_valid_reg)
        begin
            result_next.out_of_range = pend_oor_reg;
            if (pend_read_reg)
            begin
                result_next.read_value = 16'(mem_rdata);
            end
        end
    end

    // clamped configuration writes: zero reads as one, large values saturate
    always_comb
    begin
        gw_next = gw_reg;
        gh_next = gh_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GRID_WIDTH:
                begin
                    if (cfg_data == '0)
                    begin
                        gw_next = DWW'(1);
                    end
                    else if (32'(cfg_data) > 32'(MAX_WIDTH))
                    begin
                        gw_next = DWW'(MAX_WIDTH);
                    end
                    else
                    begin
                        gw_next = DWW'(cfg_data);
                    end
                end
                CFG_GRID_HEIGHT:
                begin
                    if (cfg_data == '0)
                    begin
                        gh_next = DWH'(1);
                    end
                    else if (32'(cfg_data) > 32'(MAX_HEIGHT))
                    begin
                        gh_next = DWH'(MAX_HEIGHT);
                    end
                    else
                    begin
                        gh_next = DWH'(cfg_data);
                    end
                end
                default:
                begin
                    gw_next = gw_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg         <= DWW'(GW_RST);
            gh_reg         <= DWH'(GH_RST);
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            gw_reg         <= gw_next;
            gh_reg         <= gh_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_read_reg <= pend_read_next;
        pend_oor_reg  <= pend_oor_next;
        result_reg    <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    cdt_sweep #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_sweep (
        .clk       (clk),
        .rst_n     (rst_n),
        .run       (sw_run),
        .grid_w    (gw_reg),
        .grid_h    (gh_reg),
        .rdata     (mem_rdata),
        .mem_en    (sw_en),
        .mem_we    (sw_we),
        .mem_addr  (sw_addr),
        .mem_wdata (sw_wdata),
        .stat      (sw_stat)
    );

    cdt_store #(
        .DEPTH         (DEPTH),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    `CDT_ASSERT_NOW(a_no_result_clash, pend_valid_reg, !sw_stat.done,
        "pending item result collides with sweep end")
    `CDT_ASSERT_NEXT(a_run_goes_busy, sw_run, sw_stat.busy,
        "run accepted but sweep did not start")
    `CDT_ASSERT_NEXT(a_sweep_end_strobes, sw_stat.done, (done && !result.out_of_range),
        "sweep end gave no clean result")

endmodule

// ----- rtl/cdt_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_store
// single-port distance memory, registered read data
// ----------------------------------------------------------------------------
module cdt_store #(
    parameter int DEPTH         = 16384,
    parameter int DISTANCE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         addr,
    input  logic [DISTANCE_BITS-1:0]         wdata,
    output logic [DISTANCE_BITS-1:0]         rdata
);

    logic [DISTANCE_BITS-1:0] store_mem [DEPTH];
    logic [DISTANCE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                store_mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= store_mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cdt_sweep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_sweep
// forward and backward raster passes, read-modify-write of each cell
// ----------------------------------------------------------------------------
`include "chessboard_distance_transform_unit_defines.svh"

module cdt_sweep #(
    parameter int MAX_WIDTH     = 128,
    parameter int MAX_HEIGHT    = 128,
    parameter int DISTANCE_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        run,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]              grid_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]             grid_h,
    input  logic [DISTANCE_BITS-1:0]                    rdata,
    output logic                                        mem_en,
    output logic                                        mem_we,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     mem_addr,
    output logic [DISTANCE_BITS-1:0]                    mem_wdata,
    output cdt_pkg::sweep_stat_t                        stat
);

    import cdt_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);

    sweep_state_t             state_reg, state_next;
    logic [2:0]               phase_reg, phase_next;
    logic [XW-1:0]            x_reg, x_next;
    logic [YW-1:0]            y_reg, y_next;
    logic [AW-1:0]            addr_reg, addr_next;
    logic [DISTANCE_BITS-1:0] acc_reg, acc_next;
    logic                     inb_reg, inb_next;

    logic [XW-1:0]            x_last;
    logic [YW-1:0]            y_last;
    logic                     x_lo, x_hi, y_lo, y_hi;
    nb_step_t                 step;
    logic                     issue_nb, issue_inb;
    logic [AW-1:0]            dx_off, dy_off, nb_addr;
    logic [DISTANCE_BITS-1:0] cand, acc_new;
    logic                     bwd, done;

    assign x_last = XW'(grid_w - 1'b1);
    assign y_last = YW'(grid_h - 1'b1);
    assign x_lo   = (x_reg == '0);
    assign x_hi   = (x_reg == x_last);
    assign y_lo   = (y_reg == '0);
    assign y_hi   = (y_reg == y_last);
    assign bwd    = (state_reg == SW_BWD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SW_IDLE;
            phase_reg <= PHASE_CENTER;
            inb_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            inb_reg   <= inb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        addr_reg <= addr_next;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        // neighbour for this phase; forward pass uses W, NW, N, NE
        step      = nb_step({~bwd, 2'(phase_reg - PHASE_NB_FIRST)});
        issue_nb  = (phase_reg >= PHASE_NB_FIRST) && (phase_reg <= PHASE_NB_LAST);
        issue_inb = issue_nb
                    && !(step.x_dec && x_lo) && !(step.x_inc && x_hi)
                    && !(step.y_dec && y_lo) && !(step.y_inc && y_hi);

        dx_off = step.x_inc ? AW'(1) : (step.x_dec ? '1 : '0);
        dy_off = step.y_inc ? AW'(MAX_WIDTH)
               : (step.y_dec ? (AW'(0) - AW'(MAX_WIDTH)) : '0);
        nb_addr = addr_reg + dx_off + dy_off;

        // infinity plus one stays infinity
        cand = (rdata == '1) ? rdata : (rdata + 1'b1);
        if (phase_reg == PHASE_NB_FIRST)
        begin
            acc_new = rdata;
        end
        else if (inb_reg && (cand < acc_reg))
        begin
            acc_new = cand;
        end
        else
        begin
            acc_new = acc_reg;
        end

        state_next = state_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        inb_next   = issue_inb;
        done       = 1'b0;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = addr_reg;
        mem_wdata  = acc_new;

        case (state_reg)
            SW_IDLE:
            begin
                inb_next = 1'b0;
                if (run)
                begin
                    state_next = SW_FWD;
                    phase_next = PHASE_CENTER;
                    x_next     = '0;
                    y_next     = y_last;
                end
            end
            SW_FWD, SW_BWD:
            begin
                mem_en = 1'b1;
                if (issue_inb)
                begin
                    mem_addr = nb_addr;
                end
                if (phase_reg != PHASE_CENTER)
                begin
                    acc_next = acc_new;
                end
                if (phase_reg == PHASE_WRITE)
                begin
                    mem_we     = 1'b1;
                    phase_next = PHASE_CENTER;
                    if (!bwd)
                    begin
                        // forward: y falls inside, x rises outside
                        if (!y_lo)
                        begin
                            y_next = y_reg - 1'b1;
                        end
                        else if (!x_hi)
                        begin
                            y_next = y_last;
                            x_next = x_reg + 1'b1;
                        end
                        else
                        begin
                            state_next = SW_BWD;
                            y_next     = '0;
                        end
                    end
                    else
                    begin
                        // backward: y rises inside, x falls outside
                        if (!y_hi)
                        begin
                            y_next = y_reg + 1'b1;
                        end
                        else if (!x_lo)
                        begin
                            y_next = '0;
                            x_next = x_reg - 1'b1;
                        end
                        else
                        begin
                            state_next = SW_IDLE;
                            done       = 1'b1;
                        end
                    end
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = SW_IDLE;
                phase_next = PHASE_CENTER;
            end
        endcase

        addr_next = AW'(AW'(y_next) * AW'(MAX_WIDTH) + AW'(x_next));
    end

    assign stat.busy = (state_reg != SW_IDLE);
    assign stat.done = done;

    `CDT_ASSERT_NOW(a_we_on_write_phase, mem_we, (phase_reg == PHASE_WRITE),
        "sweep writes memory outside its write phase")
    `CDT_ASSERT_NOW(a_idle_phase, (state_reg == SW_IDLE), (phase_reg == PHASE_CENTER),
        "sweep idle with a cell half done")
    `CDT_ASSERT_NEXT(a_done_idle, done, (state_reg == SW_IDLE),
        "sweep still running after its last cell")

endmodule
